### rtl/edc_pkg.sv
package edc_pkg;

	// Payload of one voxel and of one color
	typedef struct packed {
		logic signed [31:0] eig_first;
		logic signed [31:0] eig_second;
		logic signed [31:0] eig_third;
		logic [15:0]        azimuth;
		logic [15:0]        polar;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

	// Eigenvector select codes
	localparam logic [1:0] SEL_PLANAR = 2'd0;
	localparam logic [1:0] SEL_MIN    = 2'd1;
	localparam logic [1:0] SEL_LINEAR = 2'd2;
	localparam logic [1:0] SEL_NONE   = 2'd3;

	// Pipeline layout
	localparam int NUM_STAGES = 14;
	localparam int DIV_FIRST  = 4;
	localparam int DIV_LAST   = 11;

	// Sine polynomial coefficients, Q16
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [15:0] SIN_B = 16'd42048;
	localparam logic [12:0] SIN_C = 13'd4640;
	localparam logic [15:0] W_MAX = 16'hFFFF;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [14:0] QUARTER = 15'h4000;
	localparam logic [15:0] QUARTER16 = 16'h4000;

	// Restoring divider lane: num << 16 / den, saturating at W_MAX
	typedef struct packed {
		logic [33:0] den;
		logic [33:0] rem;
		logic [15:0] quo;
		logic        sat;
		logic        zero;
	} div_t;

	// Per-item control carried along the pipe
	typedef struct packed {
		logic [1:0]  sel;
		logic        l2_zero;
		logic        pla_den_zero;
		logic [15:0] azimuth;
		logic [15:0] polar;
	} ctl_t;

	// One quotient bit
	function automatic div_t div_step(div_t d);
		logic [34:0] r2;
		div_t o;
		o = d;
		r2 = {d.rem, 1'b0};
		if (r2 >= {1'b0, d.den}) begin
			o.rem = 34'(r2 - {1'b0, d.den});
			o.quo = {d.quo[14:0], 1'b1};
		end else begin
			o.rem = r2[33:0];
			o.quo = {d.quo[14:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [15:0] div_result(div_t d);
		logic [15:0] q;
		if (d.zero)
			q = '0;
		else if (d.sat)
			q = W_MAX;
		else
			q = d.quo;
		return q;
	endfunction

	// Fold a turn fraction into a quarter turn, Q14
	function automatic logic [14:0] fold_angle(logic [15:0] a);
		logic [14:0] t;
		t = a[14:0];
		if (t > QUARTER)
			t = 15'(16'h8000 - {1'b0, t});
		return t;
	endfunction

	// Magnitude of a signed 32-bit value
	function automatic logic [32:0] mag33(logic [31:0] v);
		logic [32:0] m;
		if (v[31])
			m = 33'(33'h1_0000_0000 - {1'b0, v});
		else
			m = {1'b0, v};
		return m;
	endfunction

endpackage

### rtl/eigenvector_direction_colormap.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    edc_pkg::item_t
// result    out        result_valid / result_stall edc_pkg::result_t
// config    in         cfg_we                     cfg_wdata (eigvec_select)
//
// One item per cycle while the result is not stalled. The depth is set by the two 16-bit
// restoring dividers (two quotient bits per stage over eight stages).
// Reset clears the valid bits and sets the select register to planar.
// A stalled result holds; earlier stages keep filling bubbles behind it.
module eigenvector_direction_colormap (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              item_valid,
	output logic              item_stall,
	input  edc_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output edc_pkg::result_t  result
);
	import edc_pkg::*;

	logic [1:0] sel_q;

	logic [NUM_STAGES:1]   vld_s;
	logic [NUM_STAGES-1:0] vin;
	logic [NUM_STAGES+1:1] adv;

	ctl_t        ctl_s [1:DIV_LAST];
	logic [32:0] l_s1 [3];
	div_t        lin_s [2:DIV_LAST];
	div_t        pla_s [2:DIV_LAST];

	// angle lanes: 0 sin az, 1 cos az, 2 sin polar, 3 cos polar
	logic [14:0] t_s7 [4];
	logic [14:0] t_s8 [4];
	logic [14:0] t_s9 [4];
	logic [14:0] t_s10 [4];
	logic [14:0] t2_s8 [4];
	logic [14:0] t2_s9 [4];
	logic [12:0] inner_s9 [4];
	logic [15:0] mid_s10 [4];
	logic [16:0] s_s11 [4];

	logic [15:0] w_s12;
	logic [16:0] c_s12 [3];
	logic [32:0] r_s13 [3];
	logic [7:0]  byte_s14 [3];

	logic [15:0] lin_w, pla_w, w_next;
	logic [15:0] ang [4];

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= SEL_PLANAR;
		else if (cfg_we)
			sel_q <= cfg_wdata;
	end

	// Valid bits and stage advance
	assign vin[0] = item_valid;
	assign adv[NUM_STAGES+1] = !result_stall;
	genvar g;
	generate
		for (g = 1; g <= NUM_STAGES; g++) begin : g_vld
			if (g < NUM_STAGES) begin : g_vin
				assign vin[g] = vld_s[g];
			end
			assign adv[g] = !vld_s[g] || adv[g+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (adv[g])
					vld_s[g] <= vin[g-1];
			end
		end
	endgenerate
	assign item_stall = !adv[1];

	// S1: magnitudes
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			l_s1[0] <= mag33(item.eig_first);
			l_s1[1] <= mag33(item.eig_second);
			l_s1[2] <= mag33(item.eig_third);
			ctl_s[1] <= '{sel: sel_q, l2_zero: 1'b0, pla_den_zero: 1'b0,
				azimuth: item.azimuth, polar: item.polar};
		end
	end

	// S2: numerators, denominators, zero flags
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			lin_s[2].den  <= 34'(l_s1[0]) + 34'(l_s1[1]) + 34'(l_s1[2]);
			lin_s[2].rem  <= 34'(33'(l_s1[2] - l_s1[1]));
			lin_s[2].quo  <= '0;
			lin_s[2].sat  <= 1'b0;
			lin_s[2].zero <= (l_s1[2] <= l_s1[1]) ||
				((34'(l_s1[0]) + 34'(l_s1[1]) + 34'(l_s1[2])) == '0);
			pla_s[2].den  <= 34'(l_s1[0]) + 34'(l_s1[1]);
			pla_s[2].rem  <= 34'(33'(l_s1[1] - l_s1[0]));
			pla_s[2].quo  <= '0;
			pla_s[2].sat  <= 1'b0;
			pla_s[2].zero <= (l_s1[1] <= l_s1[0]) ||
				((34'(l_s1[0]) + 34'(l_s1[1])) == '0);
			ctl_s[2] <= '{sel: ctl_s[1].sel, l2_zero: (l_s1[2] == '0),
				pla_den_zero: ((34'(l_s1[0]) + 34'(l_s1[1])) == '0),
				azimuth: ctl_s[1].azimuth, polar: ctl_s[1].polar};
		end
	end

	// S3: saturation check (ratio of one or more)
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			lin_s[3] <= '{den: lin_s[2].den, rem: lin_s[2].rem, quo: lin_s[2].quo,
				sat: !lin_s[2].zero && (lin_s[2].rem >= lin_s[2].den),
				zero: lin_s[2].zero};
			pla_s[3] <= '{den: pla_s[2].den, rem: pla_s[2].rem, quo: pla_s[2].quo,
				sat: !pla_s[2].zero && (pla_s[2].rem >= pla_s[2].den),
				zero: pla_s[2].zero};
		end
	end

	// S4..S11: two quotient bits per stage
	generate
		for (g = DIV_FIRST; g <= DIV_LAST; g++) begin : g_div
			always_ff @(posedge clk) begin
				if (adv[g]) begin
					lin_s[g] <= div_step(div_step(lin_s[g-1]));
					pla_s[g] <= div_step(div_step(pla_s[g-1]));
				end
			end
		end
		for (g = 3; g <= DIV_LAST; g++) begin : g_ctl
			always_ff @(posedge clk) begin
				if (adv[g])
					ctl_s[g] <= ctl_s[g-1];
			end
		end
	endgenerate

	assign ang[0] = ctl_s[6].azimuth;
	assign ang[1] = 16'(ctl_s[6].azimuth + QUARTER16);
	assign ang[2] = ctl_s[6].polar;
	assign ang[3] = 16'(ctl_s[6].polar + QUARTER16);

	// S7: fold; S8..S11: sine polynomial, one product per stage
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (adv[7])
				t_s7[i] <= fold_angle(ang[i]);
			if (adv[8]) begin
				t_s8[i]  <= t_s7[i];
				t2_s8[i] <= 15'((30'(t_s7[i]) * 30'(t_s7[i])) >> 14);
			end
			if (adv[9]) begin
				t_s9[i]     <= t_s8[i];
				t2_s9[i]    <= t2_s8[i];
				inner_s9[i] <= 13'((28'(SIN_C) * 28'(t2_s8[i])) >> 14);
			end
			if (adv[10]) begin
				t_s10[i]  <= t_s9[i];
				mid_s10[i] <= 16'((31'(SIN_B - 16'(inner_s9[i])) * 31'(t2_s9[i])) >> 14);
			end
			if (adv[11]) begin
				if (((32'(SIN_A - 17'(mid_s10[i])) * 32'(t_s10[i])) >> 14) > 32'(ONE_Q16))
					s_s11[i] <= ONE_Q16;
				else
					s_s11[i] <= 17'((32'(SIN_A - 17'(mid_s10[i])) * 32'(t_s10[i])) >> 14);
			end
		end
	end

	// Weight selection
	always_comb begin
		lin_w = div_result(lin_s[DIV_LAST]);
		pla_w = div_result(pla_s[DIV_LAST]);
		unique case (ctl_s[DIV_LAST].sel)
			SEL_LINEAR: w_next = lin_w;
			SEL_PLANAR: w_next = pla_w;
			SEL_MIN: begin
				if (ctl_s[DIV_LAST].pla_den_zero || lin_w < pla_w)
					w_next = lin_w;
				else
					w_next = pla_w;
			end
			default: w_next = W_MAX;
		endcase
		if (ctl_s[DIV_LAST].l2_zero)
			w_next = '0;
	end

	// S12: weight and direction components
	always_ff @(posedge clk) begin
		if (adv[12]) begin
			w_s12 <= w_next;
			c_s12[0] <= 17'((34'(s_s11[1]) * 34'(s_s11[2])) >> 16);
			c_s12[1] <= 17'((34'(s_s11[0]) * 34'(s_s11[2])) >> 16);
			c_s12[2] <= s_s11[3];
		end
	end

	// S13: blend toward white; S14: scale to a byte
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (adv[13])
				r_s13[i] <= 33'(33'(w_s12) * 33'(c_s12[i])) +
					{(ONE_Q16 - 17'(w_s12)), 16'h0000};
			if (adv[14])
				byte_s14[i] <= 8'(({8'h00, r_s13[i], 8'h00} - {8'h00, 8'h00, r_s13[i]}) >> 32);
		end
	end

	assign result_valid = vld_s[NUM_STAGES];
	assign result.red   = byte_s14[0];
	assign result.green = byte_s14[1];
	assign result.blue  = byte_s14[2];

	// Divider remainder stays below its divisor on live lanes
	a_lin_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_LAST] && !lin_s[DIV_LAST].zero && !lin_s[DIV_LAST].sat
		|-> lin_s[DIV_LAST].rem < lin_s[DIV_LAST].den)
		else $error("linear divider remainder out of range");

	a_pla_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_LAST] && !pla_s[DIV_LAST].zero && !pla_s[DIV_LAST].sat
		|-> pla_s[DIV_LAST].rem < pla_s[DIV_LAST].den)
		else $error("planar divider remainder out of range");

	// Zero third eigenvalue clears the registered S12 weight
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_LAST] && ctl_s[DIV_LAST].l2_zero && adv[12] |=> w_s12 == '0)
		else $error("zero third eigenvalue did not clear the weight");

	// Stalled output stage holds its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NUM_STAGES] && result_stall |=> vld_s[NUM_STAGES] && $stable(byte_s14[0]))
		else $error("output stage changed while stalled");

endmodule

### verif/eigenvector_direction_colormap_checker.sv
module eigenvector_direction_colormap_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             item_valid,
	input  logic             item_stall,
	input  edc_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  edc_pkg::result_t result,
	output int               fail_count,
	output int               colors_pending
);
	import edc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0] sel_q;
	result_t    color_queue[$];

	assign colors_pending = color_queue.size();

	function automatic logic [63:0] magnitude(logic [31:0] v);
		return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
	endfunction

	// |sin| of a turn fraction, Q16
	function automatic logic [63:0] sine_mag(logic [15:0] a);
		logic [63:0] t, t2, inner, mid, s;
		t = {49'd0, a[14:0]};
		if (t > 64'h4000)
			t = 64'h8000 - t;
		t2 = (t * t) >> 14;
		inner = (64'd4640 * t2) >> 14;
		mid = ((64'd42048 - inner) * t2) >> 14;
		s = ((64'd102944 - mid) * t) >> 14;
		if (s > 64'd65536)
			s = 64'd65536;
		return s;
	endfunction

	function automatic logic [63:0] weight_term(logic [63:0] pos, logic [63:0] neg,
		logic [63:0] den);
		logic [63:0] q;
		if (den == 0 || pos <= neg)
			return 0;
		q = ((pos - neg) << 16) / den;
		return q > 64'hFFFF ? 64'hFFFF : q;
	endfunction

	function automatic logic [7:0] shade(logic [63:0] w, logic [63:0] c);
		logic [63:0] r;
		r = w * c + (64'd65536 - w) * 64'd65536;
		return 8'((r * 64'd255) >> 32);
	endfunction

	function automatic result_t predict_color(item_t v, logic [1:0] sel);
		logic [63:0] l0, l1, l2, w, lin, pla, sp, x, y, z;
		result_t c;
		l0 = magnitude(v.eig_first);
		l1 = magnitude(v.eig_second);
		l2 = magnitude(v.eig_third);
		w = 64'hFFFF;
		lin = weight_term(l2, l1, l0 + l1 + l2);
		pla = weight_term(l1, l0, l0 + l1);
		case (sel)
			SEL_LINEAR: begin
				w = lin;
			end
			SEL_MIN: begin
				w = (l0 + l1 == 0) ? lin : (lin < pla ? lin : pla);
			end
			SEL_PLANAR: begin
				w = pla;
			end
			default: ;
		endcase
		if (l2 == 0)
			w = 0;
		sp = sine_mag(v.polar);
		x = (sine_mag(v.azimuth + 16'h4000) * sp) >> 16;
		y = (sine_mag(v.azimuth) * sp) >> 16;
		z = sine_mag(v.polar + 16'h4000);
		c.red = shade(w, x);
		c.green = shade(w, y);
		c.blue = shade(w, z);
		return c;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// track register, predict on accepted items, compare accepted colors
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sel_q <= SEL_PLANAR;
			fail_count = 0;
		end else begin
			if (item_valid && !item_stall)
				color_queue.push_back(predict_color(item, sel_q));
			if (result_valid && !result_stall) begin
				if (color_queue.size() == 0) begin
					report_mismatch("unexpected color", 0, 0);
				end else begin
					want = color_queue.pop_front();
					if (result.red != want.red)
						report_mismatch("red", result.red, want.red);
					if (result.green != want.green)
						report_mismatch("green", result.green, want.green);
					if (result.blue != want.blue)
						report_mismatch("blue", result.blue, want.blue);
				end
			end
			if (cfg_we)
				sel_q <= cfg_wdata;
		end
	end
endmodule

### verif/eigenvector_direction_colormap_test.sv
module eigenvector_direction_colormap_test;
	import edc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	logic    clk = 0;
	logic    arst_n = 0;
	logic    cfg_we = 0;
	logic [1:0] cfg_wdata = SEL_PLANAR;
	logic    item_valid = 0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 0;
	result_t result;
	int      fail_count;
	int      colors_pending;
	int      idle_cycles = 0;
	bit      stall_random = 1;

	always #10 clk = ~clk;

	eigenvector_direction_colormap dut (.*);

	eigenvector_direction_colormap_checker checker_i (.*);

	function automatic int gap_length();
		if ($urandom_range(0, 2) == 0)
			return 0;
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
	endfunction

	function automatic logic [31:0] eigen_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 0;
			3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			4: return 32'($urandom_range(1, 8) << 16);
			default: return $urandom;
		endcase
	endfunction

	// hold one item until accepted; valid drops only for a real gap
	task automatic send_voxel(item_t v);
		int gap;
		gap = gap_length();
		if (gap != 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		item <= v;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic send_random_voxel();
		item_t v;
		v.eig_first = eigen_value();
		v.eig_second = eigen_value();
		v.eig_third = eigen_value();
		v.azimuth = $urandom;
		v.polar = $urandom;
		send_voxel(v);
	endtask

	task automatic drain();
		item_valid <= 0;
		@(posedge clk);
		while (colors_pending != 0) @(posedge clk);
		repeat (NUM_STAGES + 4) @(posedge clk);
	endtask

	task automatic write_select(logic [1:0] sel);
		cfg_we <= 1;
		cfg_wdata <= sel;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// receiver stall: random bursts, with calm stretches
	always @(posedge clk) begin
		if (stall_random)
			result_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 9) != 0);
		else
			result_stall <= 0;
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** eigenvector_direction_colormap: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [1:0] sels[5];
		item_t v;
		sels = '{SEL_PLANAR, SEL_LINEAR, SEL_MIN, SEL_NONE, SEL_PLANAR};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: special cases under every select
		foreach (sels[s]) begin
			write_select(sels[s]);
			v = '{32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 16'h0000, 16'h4000};
			send_voxel(v);
			v = '{32'h0, 32'h0, 32'h0005_0000, 16'hFFFF, 16'hFFFF};
			send_voxel(v);
			v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 16'h8000};
			send_voxel(v);
			v = '{32'h0, 32'h0001_0000, 32'h0, 16'h2000, 16'hC000};
			send_voxel(v);
			v = '{32'h0, 32'h0, 32'h0001_0000, 16'h8000, 16'h2000};
			send_voxel(v);
			drain();
		end
		// random phases with random select settings; the last uses none
		for (int p = 0; p < 8; p++) begin
			write_select(p == 7 ? SEL_NONE : 2'($urandom_range(0, 3)));
			stall_random = (p != 3);
			for (int i = 0; i < 120; i++)
				send_random_voxel();
			drain();
		end
		stall_random = 1;
		if (fail_count == 0)
			$display("** eigenvector_direction_colormap: PASSED **");
		else
			$display("** eigenvector_direction_colormap: FAILED **");
		$finish;
	end
endmodule
